@@ rtl/core/upd_pkg.sv @@
// -----------------------------------------------------------------------------
// upd_pkg
// Shared types, character codes and hex helpers for the URL percent decoder.
// -----------------------------------------------------------------------------
package upd_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int MAX_RES     = 3;
	localparam int RES_CNT_W   = 2;

	localparam logic [7:0] CH_PERCENT    = 8'h25; // '%'
	localparam logic [7:0] CH_PLUS       = 8'h2B; // '+'
	localparam logic [7:0] CH_SPACE      = 8'h20; // ' '
	localparam logic [7:0] CH_LOWER_BASE = 8'h57; // 'W', 'a' - 10
	localparam logic [7:0] CH_ZERO       = 8'h30; // '0'
	localparam logic [7:0] CASE_BIT      = 8'h20;

	localparam logic [COUNT_WIDTH-1:0] CAP_RESET = {COUNT_WIDTH{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PLUS_AS_SPACE   = 2'd0,
		REG_OUTPUT_CAPACITY = 2'd1
	} cfg_reg_e;

	typedef enum logic [1:0] {
		HOLD_NONE  = 2'd0,
		HOLD_PCT   = 2'd1,
		HOLD_DIGIT = 2'd2
	} hold_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]             out_byte;
		logic                   byte_valid;
		logic                   end_of_run;
		logic                   message_done;
		logic [COUNT_WIDTH-1:0] decoded_length;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_word_t;

	// one queued result, flags are added at the output
	typedef struct packed {
		logic [7:0]             out_byte;
		logic                   byte_valid;
		logic [COUNT_WIDTH-1:0] decoded_length;
	} res_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] t;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - CH_ZERO;
		end else begin
			t = (c | CASE_BIT) - CH_LOWER_BASE;
		end
		return t[3:0];
	endfunction

endpackage

@@ rtl/core/upd_ifs.sv @@
// -----------------------------------------------------------------------------
// upd_ifs
// Valid/ready channels of the URL percent decoder: raw bytes, decoded words,
// and the configuration write port.
// -----------------------------------------------------------------------------
interface upd_raw_if;
	import upd_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface upd_dec_if;
	import upd_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface upd_cfg_if;
	import upd_pkg::*;
	logic      valid;
	logic      ready;
	cfg_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/core/url_percent_decoder_top.sv @@
// -----------------------------------------------------------------------------
// url_percent_decoder_top
// Streaming percent decoder for URL and form strings, one raw byte per word.
// -----------------------------------------------------------------------------
// raw:     input words {in_byte, last_byte}; last_byte closes the string.
// decoded: result words {out_byte, byte_valid, end_of_run, message_done,
//          decoded_length}. One raw word yields zero to three result words;
//          end_of_run marks the last of them, message_done the one that
//          closes the string (byte_valid is 0 if that word carries no byte).
// cfg:     always ready; index 0 = plus_as_space, 1 = output_capacity.
//          Write only while no word is in flight.
// Flow: the first result of a word is offered once it has passed the input
// register, then the result buffer. One raw word is taken per cycle while
// each yields at most one result and the receiver is ready; a word that
// yields several results holds the result buffer until all are taken, which
// sets the rate for escape flushes.
// A raw word can still be taken while the last result of the previous one
// waits, since the input register parts the two sides.
// Reset clears the hold state, byte count and both buffers; the registers
// return to plus_as_space 0 and output_capacity 65535. A stalled receiver
// freezes the result buffer and, after one more word, the input.
// -----------------------------------------------------------------------------
module url_percent_decoder_top (
	input  logic      clk,
	input  logic      arst_n,
	upd_raw_if.sink   raw,
	upd_dec_if.source decoded,
	upd_cfg_if.sink   cfg
);
	import upd_pkg::*;

	logic                   plus_q;
	logic [COUNT_WIDTH-1:0] cap_q;

	logic                   v_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;

	hold_t                  hold_q, hold_nx;
	logic [7:0]             held_q, held_nx;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_nx;

	res_t                   ent_s2 [MAX_RES];
	logic [RES_CNT_W-1:0]   rem_q;
	logic [RES_CNT_W-1:0]   idx_q;
	logic                   last_s2;

	logic [7:0]             cand [MAX_RES];
	logic [RES_CNT_W-1:0]   cand_n;
	logic [RES_CNT_W-1:0]   room;
	logic [RES_CNT_W-1:0]   keep;
	logic [RES_CNT_W-1:0]   n_load;
	logic [COUNT_WIDTH:0]   diff;
	res_t                   ent_nx [MAX_RES];
	logic                   do_plain;
	logic                   hex;
	logic                   move;
	logic                   raw_ready;
	logic                   out_fire;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plus_q <= 1'b0;
			cap_q  <= CAP_RESET;
		end else if (cfg.valid) begin
			case (cfg_reg_e'(cfg.data.reg_index))
				REG_PLUS_AS_SPACE:   plus_q <= cfg.data.wdata[0];
				REG_OUTPUT_CAPACITY: cap_q  <= cfg.data.wdata[COUNT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// handshake: s1 empties into the result buffer once that will be free
	assign out_fire  = decoded.valid && decoded.ready;
	assign move      = v_s1 && ((rem_q == '0) || ((rem_q == RES_CNT_W'(1)) && decoded.ready));
	assign raw_ready = !v_s1 || move;
	assign raw.ready = raw_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (raw_ready) begin
			v_s1 <= raw.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (raw.valid && raw_ready) begin
			byte_s1 <= raw.data.in_byte;
			last_s1 <= raw.data.last_byte;
		end
	end

	// decode one byte into up to three candidate output bytes
	always_comb begin
		cand     = '{default: '0};
		cand_n   = '0;
		hold_nx  = hold_q;
		held_nx  = held_q;
		do_plain = 1'b0;
		hex      = is_hex(byte_s1);

		case (hold_q)
			HOLD_NONE: begin
				do_plain = 1'b1;
			end
			HOLD_PCT: begin
				if (hex) begin
					hold_nx = HOLD_DIGIT;
					held_nx = byte_s1;
				end else begin
					cand[cand_n] = CH_PERCENT;
					cand_n       = cand_n + 1'b1;
					hold_nx      = HOLD_NONE;
					do_plain     = 1'b1;
				end
			end
			HOLD_DIGIT: begin
				if (hex) begin
					cand[cand_n] = {hex_val(held_q), hex_val(byte_s1)};
					cand_n       = cand_n + 1'b1;
				end else begin
					cand[cand_n] = CH_PERCENT;
					cand_n       = cand_n + 1'b1;
					cand[cand_n] = held_q;
					cand_n       = cand_n + 1'b1;
					do_plain     = 1'b1;
				end
				hold_nx = HOLD_NONE;
				held_nx = '0;
			end
			default: begin
				hold_nx  = HOLD_NONE;
				do_plain = 1'b1;
			end
		endcase

		if (do_plain) begin
			if (byte_s1 == CH_PERCENT) begin
				hold_nx = HOLD_PCT;
			end else if (plus_q && byte_s1 == CH_PLUS) begin
				cand[cand_n] = CH_SPACE;
				cand_n       = cand_n + 1'b1;
			end else begin
				cand[cand_n] = byte_s1;
				cand_n       = cand_n + 1'b1;
			end
		end

		// end of string: flush whatever is held
		if (last_s1) begin
			if (hold_nx != HOLD_NONE) begin
				cand[cand_n] = CH_PERCENT;
				cand_n       = cand_n + 1'b1;
			end
			if (hold_nx == HOLD_DIGIT) begin
				cand[cand_n] = held_nx;
				cand_n       = cand_n + 1'b1;
			end
			hold_nx = HOLD_NONE;
			held_nx = '0;
		end
	end

	// capacity trim and result buffer load
	always_comb begin
		diff = {1'b0, cap_q} - {1'b0, cnt_q};
		if (cap_q <= cnt_q) begin
			room = '0;
		end else if (diff >= (COUNT_WIDTH+1)'(MAX_RES)) begin
			room = RES_CNT_W'(MAX_RES);
		end else begin
			room = diff[RES_CNT_W-1:0];
		end
		keep = (cand_n < room) ? cand_n : room;

		for (int i = 0; i < MAX_RES; i++) begin
			ent_nx[i].out_byte       = cand[i];
			ent_nx[i].byte_valid     = 1'b1;
			ent_nx[i].decoded_length = cnt_q + COUNT_WIDTH'(i + 1);
		end
		n_load = keep;
		// closing word with no byte to carry
		if (last_s1 && keep == '0) begin
			ent_nx[0].out_byte       = '0;
			ent_nx[0].byte_valid     = 1'b0;
			ent_nx[0].decoded_length = cnt_q;
			n_load                   = RES_CNT_W'(1);
		end
		cnt_nx = last_s1 ? '0 : cnt_q + COUNT_WIDTH'(keep);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HOLD_NONE;
			held_q <= '0;
			cnt_q  <= '0;
		end else if (move) begin
			hold_q <= hold_nx;
			held_q <= held_nx;
			cnt_q  <= cnt_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			idx_q   <= '0;
			last_s2 <= 1'b0;
		end else if (move) begin
			rem_q   <= n_load;
			idx_q   <= '0;
			last_s2 <= last_s1;
		end else if (out_fire) begin
			rem_q <= rem_q - 1'b1;
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			ent_s2 <= ent_nx;
		end
	end

	assign decoded.valid                = (rem_q != '0);
	assign decoded.data.out_byte        = ent_s2[idx_q].out_byte;
	assign decoded.data.byte_valid      = ent_s2[idx_q].byte_valid;
	assign decoded.data.decoded_length  = ent_s2[idx_q].decoded_length;
	assign decoded.data.end_of_run      = (rem_q == RES_CNT_W'(1));
	assign decoded.data.message_done    = (rem_q == RES_CNT_W'(1)) && last_s2;

endmodule

@@ rtl/core/upd_checker.sv @@
// -----------------------------------------------------------------------------
// upd_checker
// Port-level checks on the decoded channel of the URL percent decoder.
// -----------------------------------------------------------------------------
module upd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input upd_pkg::out_item_t out_data
);
	import upd_pkg::*;

	logic [COUNT_WIDTH-1:0] prev_len_q;
	logic                   fresh_q;

	// tracks the length of the last delivered byte within the string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_len_q <= '0;
			fresh_q    <= 1'b1;
		end else if (out_valid && out_ready) begin
			if (out_data.message_done) begin
				fresh_q <= 1'b1;
			end else if (out_data.byte_valid) begin
				fresh_q <= 1'b0;
			end
			if (out_data.byte_valid) begin
				prev_len_q <= out_data.decoded_length;
			end
		end
	end

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("decoded word changed while stalled");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.message_done |-> out_data.end_of_run)
		else $error("message_done without end_of_run");

	a_empty_is_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.byte_valid |-> out_data.message_done)
		else $error("byteless word that does not close the string");

	a_length_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.byte_valid |->
			out_data.decoded_length ==
				(fresh_q ? COUNT_WIDTH'(1) : prev_len_q + COUNT_WIDTH'(1)))
		else $error("decoded_length does not count up by one");

endmodule

bind url_percent_decoder_top upd_checker u_upd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (decoded.valid),
	.out_ready (decoded.ready),
	.out_data  (decoded.data)
);

@@ tb/sv/tb_top.sv @@
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for url_percent_decoder_top. A directed table walks the
// byte extremes, escapes in both cases, broken and trailing escapes, form mode
// and the capacity limits. Random well-formed strings with broken escapes and
// raw noise follow, under several register settings. Every accepted raw word
// runs through an in-bench decoder model. Each decoded word is compared, field
// by field, against the oldest expected word. Both sides idle at random, and
// one long receiver stall backs the block up.
// -----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import upd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam int                   DRAIN_CYC   = 4;
	localparam int                   LONG_STALL  = 120;
	localparam int                   N_PHASES    = 7;
	localparam int                   PHASE_WORDS = 23;
	localparam out_item_t            NO_EXP      = '0;

	typedef enum logic [1:0] {
		ROW_WORD,
		ROW_PLUS,
		ROW_CAP
	} row_kind_e;

	typedef struct {
		row_kind_e   kind;
		logic [15:0] val;
		logic        last;
		logic        typed;
		out_item_t   exp;
	} dir_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	upd_raw_if raw_ch ();
	upd_dec_if dec_ch ();
	upd_cfg_if cfg_ch ();

	url_percent_decoder_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.raw     (raw_ch),
		.decoded (dec_ch),
		.cfg     (cfg_ch)
	);

	// decoder model state, reset values
	logic                   plus_mode = 1'b0;
	logic [COUNT_WIDTH-1:0] cap_bytes = CAP_RESET;
	hold_t                  hold_st   = HOLD_NONE;
	logic [7:0]             held_b    = 8'h00;
	logic [COUNT_WIDTH-1:0] n_emitted = '0;

	out_item_t step_words[$];
	out_item_t expected_decoded_q[$];
	int        mismatch_count = 0;
	bit        burst_mode     = 1'b0;
	bit        stall_req      = 1'b0;

	// directed table; exp typed in only for the obvious rows
	dir_row_t dir_tab [29] = '{
		'{ROW_WORD, 16'("A"),        1'b0, 1'b1, {8'h41, 1'b1, 1'b1, 1'b0, 16'd1}},
		'{ROW_WORD, 16'h00,          1'b0, 1'b1, {8'h00, 1'b1, 1'b1, 1'b0, 16'd2}},
		'{ROW_WORD, 16'hFF,          1'b1, 1'b1, {8'hFF, 1'b1, 1'b1, 1'b1, 16'd3}},
		'{ROW_WORD, 16'(CH_PERCENT), 1'b1, 1'b1, {CH_PERCENT, 1'b1, 1'b1, 1'b1, 16'd1}},
		'{ROW_WORD, 16'(CH_PERCENT), 1'b0, 1'b0, NO_EXP},
		'{ROW_WORD, 16'("a"),        1'b0, 1'b0, NO_EXP},
		'{ROW_WORD, 16'("F"),        1'b0, 1'b0, NO_EXP},
		'{ROW_WORD, 16'(CH_PERCENT), 1'b0, 1'b0, NO_EXP},
		'{ROW_WORD, 16'("4"),        1'b0, 1'b0, NO_EXP},
		'{ROW_WORD, 16'("g"),        1'b0, 1'b0, NO_EXP},
		'{ROW_WORD, 16'(CH_PERCENT), 1'b0, 1'b0, NO_EXP},
		'{ROW_WORD, 16'(CH_PERCENT), 1'b0, 1'b0, NO_EXP},
		'{ROW_WORD, 16'("2"),        1'b0, 1'b0, NO_EXP},
		'{ROW_WORD, 16'("0"),        1'b0, 1'b0, NO_EXP},
		'{ROW_WORD, 16'(CH_PLUS),    1'b0, 1'b0, NO_EXP},
		'{ROW_WORD, 16'(CH_PERCENT), 1'b0, 1'b0, NO_EXP},
		'{ROW_WORD, 16'("9"),        1'b1, 1'b0, NO_EXP},
		'{ROW_PLUS, 16'h0001,        1'b0, 1'b0, NO_EXP},
		'{ROW_WORD, 16'(CH_PLUS),    1'b1, 1'b1, {CH_SPACE, 1'b1, 1'b1, 1'b1, 16'd1}},
		'{ROW_CAP,  16'h0000,        1'b0, 1'b0, NO_EXP},
		'{ROW_WORD, 16'("x"),        1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1, 16'd0}},
		'{ROW_CAP,  16'h0002,        1'b0, 1'b0, NO_EXP},
		'{ROW_WORD, 16'("a"),        1'b0, 1'b0, NO_EXP},
		'{ROW_WORD, 16'("b"),        1'b0, 1'b0, NO_EXP},
		'{ROW_WORD, 16'(CH_PERCENT), 1'b0, 1'b0, NO_EXP},
		'{ROW_WORD, 16'("4"),        1'b0, 1'b0, NO_EXP},
		'{ROW_WORD, 16'("1"),        1'b0, 1'b0, NO_EXP},
		'{ROW_WORD, 16'("z"),        1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1, 16'd2}},
		'{ROW_CAP,  16'hFFFF,        1'b0, 1'b0, NO_EXP}
	};

	function automatic logic is_hex_digit(input logic [7:0] c);
		return c inside {["0":"9"], ["a":"f"], ["A":"F"]};
	endfunction

	// letters of both cases share the low nibble offset
	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		return (c <= "9") ? c[3:0] : 4'(c[3:0] + 4'd9);
	endfunction

	function automatic void put_word(input logic [7:0] b, input logic v);
		out_item_t w;
		w.out_byte       = b;
		w.byte_valid     = v;
		w.end_of_run     = 1'b0;
		w.message_done   = 1'b0;
		w.decoded_length = n_emitted;
		step_words.push_back(w);
	endfunction

	function automatic void emit_byte(input logic [7:0] b);
		if (n_emitted >= cap_bytes)
			return;
		n_emitted = n_emitted + 1'b1;
		put_word(b, 1'b1);
	endfunction

	function automatic void take_plain(input logic [7:0] b);
		if (b == CH_PERCENT) begin
			hold_st = HOLD_PCT;
		end else if (plus_mode && b == CH_PLUS) begin
			emit_byte(CH_SPACE);
		end else begin
			emit_byte(b);
		end
	endfunction

	function automatic void predict_decode(input logic [7:0] b, input logic last);
		out_item_t w;
		step_words.delete();
		case (hold_st)
			HOLD_NONE: take_plain(b);
			HOLD_PCT: begin
				if (is_hex_digit(b)) begin
					held_b  = b;
					hold_st = HOLD_DIGIT;
				end else begin
					emit_byte(CH_PERCENT);
					hold_st = HOLD_NONE;
					take_plain(b);
				end
			end
			default: begin
				if (is_hex_digit(b)) begin
					emit_byte({nibble_of(held_b), nibble_of(b)});
					hold_st = HOLD_NONE;
					held_b  = 8'h00;
				end else begin
					emit_byte(CH_PERCENT);
					emit_byte(held_b);
					hold_st = HOLD_NONE;
					held_b  = 8'h00;
					take_plain(b);
				end
			end
		endcase
		if (last) begin
			if (hold_st != HOLD_NONE)
				emit_byte(CH_PERCENT);
			if (hold_st == HOLD_DIGIT)
				emit_byte(held_b);
			hold_st = HOLD_NONE;
			held_b  = 8'h00;
			if (step_words.size() == 0)
				put_word(8'h00, 1'b0);
			w = step_words.pop_back();
			w.message_done = 1'b1;
			step_words.push_back(w);
			n_emitted = '0;
		end
		if (step_words.size() != 0) begin
			w = step_words.pop_back();
			w.end_of_run = 1'b1;
			step_words.push_back(w);
		end
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 0;
		if (r < 9)
			return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	function automatic logic [7:0] rand_hex_char();
		int n;
		n = $urandom_range(0, 15);
		if (n < 10)
			return 8'(CH_ZERO + n);
		if ($urandom_range(0, 1))
			return 8'("A" + n - 10);
		return 8'("a" + n - 10);
	endfunction

	task automatic push_raw(input logic [7:0] b, input logic last, input logic typed,
			input out_item_t exp);
		int gap;
		gap = burst_mode ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			raw_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		raw_ch.valid <= 1'b1;
		raw_ch.data  <= '{in_byte: b, last_byte: last};
		do @(posedge clk); while (!raw_ch.ready);
		predict_decode(b, last);
		if (typed) begin
			expected_decoded_q.push_back(exp);
		end else begin
			foreach (step_words[i])
				expected_decoded_q.push_back(step_words[i]);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] wd);
		@(negedge clk);
		raw_ch.valid <= 1'b0;
		while (expected_decoded_q.size() != 0) @(negedge clk);
		// a dropped byte may still be inside with nothing expected
		repeat (DRAIN_CYC) @(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= '{reg_index: idx, wdata: wd};
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_PLUS_AS_SPACE)
			plus_mode = wd[0];
		else if (idx == REG_OUTPUT_CAPACITY)
			cap_bytes = wd;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver: alternating ready and stall runs, one long forced stall
	initial begin
		int run_left;
		bit run_ready;
		run_left     = 0;
		run_ready    = 1'b0;
		dec_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_req) begin
				stall_req = 1'b0;
				run_ready = 1'b0;
				run_left  = LONG_STALL;
			end else if (run_left == 0) begin
				run_ready = ~run_ready;
				if (run_ready)
					run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
						: $urandom_range(1, 12);
				else
					run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
						: $urandom_range(1, 3);
			end
			dec_ch.ready <= run_ready;
			run_left--;
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		if (arst_n && dec_ch.valid && dec_ch.ready) begin
			got = dec_ch.data;
			if (expected_decoded_q.size() == 0) begin
				$display("%0t unexpected word: expected none, got %h", $time, got);
				mismatch_count++;
			end else begin
				want = expected_decoded_q.pop_front();
				if (got.out_byte !== want.out_byte) begin
					$display("%0t out_byte: expected %h, got %h", $time,
						want.out_byte, got.out_byte);
					mismatch_count++;
				end
				if (got.byte_valid !== want.byte_valid) begin
					$display("%0t byte_valid: expected %b, got %b", $time,
						want.byte_valid, got.byte_valid);
					mismatch_count++;
				end
				if (got.end_of_run !== want.end_of_run) begin
					$display("%0t end_of_run: expected %b, got %b", $time,
						want.end_of_run, got.end_of_run);
					mismatch_count++;
				end
				if (got.message_done !== want.message_done) begin
					$display("%0t message_done: expected %b, got %b", $time,
						want.message_done, got.message_done);
					mismatch_count++;
				end
				if (got.decoded_length !== want.decoded_length) begin
					$display("%0t decoded_length: expected %0d, got %0d", $time,
						want.decoded_length, got.decoded_length);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		logic [7:0]  str_q[$];
		logic [15:0] wd;
		int          phase_words;
		raw_ch.valid = 1'b0;
		raw_ch.data  = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data  = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) begin
			case (dir_tab[i].kind)
				ROW_WORD: push_raw(dir_tab[i].val[7:0], dir_tab[i].last, dir_tab[i].typed,
					dir_tab[i].exp);
				ROW_PLUS: write_reg(REG_PLUS_AS_SPACE, dir_tab[i].val);
				default:  write_reg(REG_OUTPUT_CAPACITY, dir_tab[i].val);
			endcase
		end

		// unmapped indexes must leave both registers alone
		write_reg(REG_SPARE_2, 16'($urandom));
		write_reg(REG_SPARE_3, 16'($urandom));

		for (int ph = 0; ph < N_PHASES; ph++) begin
			wd = 16'($urandom);
			wd[0] = ph[0];
			write_reg(REG_PLUS_AS_SPACE, wd);
			case (ph)
				1:       wd = 16'h0000;
				2:       wd = 16'h0001;
				3:       wd = 16'($urandom_range(2, 6));
				5:       wd = 16'($urandom);
				6:       wd = 16'($urandom_range(3, 10));
				default: wd = 16'hFFFF;
			endcase
			write_reg(REG_OUTPUT_CAPACITY, wd);
			burst_mode = (ph == 4);
			if (ph == 4)
				stall_req = 1'b1;
			phase_words = 0;
			while (phase_words < PHASE_WORDS) begin
				str_q.delete();
				repeat ($urandom_range(1, 8)) begin
					case ($urandom_range(0, 9))
						0, 1, 2: str_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
						3:       str_q.push_back(CH_PLUS);
						4, 5, 6: begin
							str_q.push_back(CH_PERCENT);
							str_q.push_back(rand_hex_char());
							str_q.push_back(rand_hex_char());
						end
						7: begin
							// broken escape, unless the bytes that follow happen to be hex digits
							str_q.push_back(CH_PERCENT);
							if ($urandom_range(0, 1))
								str_q.push_back(rand_hex_char());
						end
						default: str_q.push_back(8'($urandom));
					endcase
				end
				foreach (str_q[i])
					push_raw(str_q[i], i == str_q.size() - 1, 1'b0, NO_EXP);
				phase_words += str_q.size();
			end
			burst_mode = 1'b0;
		end

		@(negedge clk);
		raw_ch.valid <= 1'b0;
		while (expected_decoded_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
